[rtl/assert_macros.svh]
// Assertion macros used by the checker module of the timeout scheduler.
// Depends on nothing; each user takes it in with a bare include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler checker: assertion failed");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler checker: assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("scheduler checker: assertion failed");

`endif

[rtl/mts_pkg.sv]
// Package of the multiplexed timeout scheduler: widths, codes and types.
// Depends on nothing; all files but the RAM and the macro header import it.
`default_nettype none

package mts_pkg;

   localparam int MAX_TIMERS_DEF = 8;
   localparam int ID_BITS_DEF    = 8;
   localparam int MODE_W         = 2;
   localparam int ID_PORT_W      = 8;
   localparam int MS_W           = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_START  = 2'd0,
      MODE_STOP   = 2'd1,
      MODE_EXPIRE = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ARMED  = 5'b00010,
      ST_READ   = 5'b00100,
      ST_PROC   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   typedef struct packed {
      logic [MS_W-1:0] a;
      logic [MS_W-1:0] b;
      logic [MS_W-1:0] cmp_val;
   } alu_req_type;

   typedef struct packed {
      logic [MS_W-1:0] diff;
      logic            less;
   } alu_res_type;

endpackage

`default_nettype wire

[rtl/mts_if.sv]
// Channel interfaces of the timeout scheduler: request and response.
// Depends on mts_pkg for the payload widths.
`default_nettype none

interface mts_req_if import mts_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [ID_PORT_W-1:0] timer_id;
   logic [MS_W-1:0]      timeout_ms;
   logic [MS_W-1:0]      remaining_ms;

   modport source (output valid, mode, timer_id, timeout_ms, remaining_ms, input ready);
   modport sink   (input valid, mode, timer_id, timeout_ms, remaining_ms, output ready);
endinterface

interface mts_rsp_if import mts_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 fired_valid;
   logic [ID_PORT_W-1:0] fired_id;
   logic                 program_valid;
   logic [MS_W-1:0]      program_ms;
   logic                 table_full;

   modport source (output valid, fired_valid, fired_id, program_valid, program_ms,
                   table_full, input ready);
   modport sink   (input valid, fired_valid, fired_id, program_valid, program_ms,
                   table_full, output ready);
endinterface

`default_nettype wire

[rtl/multiplexed_timeout_scheduler.sv]
// Top level of the multiplexed timeout scheduler: sequencer and entry table.
// Depends on mts_pkg, mts_if, mts_ram and mts_alu.
`default_nettype none
// Usage
// The request channel carries one command per transfer: start (or restart) a
// software timer with a timeout, stop a timer, or report that the hardware
// timer has expired. The response channel returns one result per request: the
// timer that fired (on an expiry), the value to load into the hardware timer,
// and a flag when a start found the table full.
// A start or an expiry first fetches the armed entry, then sweeps the table
// entry by entry; a stop or an ignored command skips that fetch, and any item
// on an empty table goes straight to the final step. The entry RAM has a
// single read port and there is one shared subtract-and-compare unit, so
// each entry is visited in a read step followed by a process step. The
// response becomes valid in the same cycle as the sequencer returns to idle,
// in which the next request can be accepted. Requests are taken only while
// the sequencer is idle; the finished response waits in an output register,
// so a new request is taken while the previous response is still held. If
// the receiver stalls, the sequencer holds the next result in its final step
// until the register frees.
// Reset empties the table at once; the entry RAM needs no clearing pass since
// only entries below the fill count are ever read.

module multiplexed_timeout_scheduler import mts_pkg::*; #(
   parameter int MAX_TIMERS = MAX_TIMERS_DEF,
   parameter int ID_BITS    = ID_BITS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   mts_req_if.sink    req_chan,
   mts_rsp_if.source  rsp_chan
);

   localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int CNT_W = $clog2(MAX_TIMERS + 1);
   localparam int ENT_W = ID_BITS + MS_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TIMERS);

   // Sequencer state and the latched request.
   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [MS_W-1:0]    tmo_ff, tmo_in;
   logic [MS_W-1:0]    rem_ff, rem_in;

   // Table bookkeeping: fill count and the position loaded into the hardware timer.
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   armed_ff, armed_in;

   // Working registers of one sweep over the table.
   logic [MS_W-1:0]    amount_ff, amount_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   dst_ff, dst_in;
   logic               found_ff, found_in;
   logic               best_valid_ff, best_valid_in;
   logic [MS_W-1:0]    best_t_ff, best_t_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic               fired_valid_ff, fired_valid_in;
   logic [ID_BITS-1:0] fired_id_ff, fired_id_in;

   // Output register of the response channel.
   logic               out_valid_ff, out_valid_in;
   logic               res_fired_valid_ff, res_fired_valid_in;
   logic [ID_BITS-1:0] res_fired_id_ff, res_fired_id_in;
   logic               res_prog_valid_ff, res_prog_valid_in;
   logic [MS_W-1:0]    res_prog_ms_ff, res_prog_ms_in;
   logic               res_full_ff, res_full_in;

   // Entry RAM and shared unit.
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENT_W-1:0]   ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENT_W-1:0]   ram_rd_data;
   logic [ID_BITS-1:0] ent_id;
   logic [MS_W-1:0]    ent_t;
   alu_req_type        alu_req;
   alu_res_type        alu_res;

   logic [ID_BITS-1:0]   req_id;
   logic [ID_PORT_W-1:0] fired_id_port;
   logic                 is_start, is_stop, is_expire;
   logic                 match, skip, take, room;
   logic                 append, fin_valid;
   logic [MS_W-1:0]      fin_best_t;
   logic [IDX_W-1:0]     fin_best_idx;

   // If ID_BITS fits the port, only the low ID_BITS of the incoming id are kept and
   // the fired id is zero-extended onto the eight-bit port; if wider, the reverse.
   generate
      if (ID_BITS <= ID_PORT_W) begin : g_id_narrow
         assign req_id        = req_chan.timer_id[ID_BITS-1:0];
         assign fired_id_port = ID_PORT_W'(res_fired_id_ff);
      end else begin : g_id_wide
         assign req_id        = {{(ID_BITS-ID_PORT_W){1'b0}}, req_chan.timer_id};
         assign fired_id_port = res_fired_id_ff[ID_PORT_W-1:0];
      end
   endgenerate

   mts_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_TIMERS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mts_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   assign ent_id = ram_rd_data[ENT_W-1:MS_W];
   assign ent_t  = ram_rd_data[MS_W-1:0];

   assign is_start  = (mode_ff == MODE_START);
   assign is_stop   = (mode_ff == MODE_STOP);
   assign is_expire = (mode_ff == MODE_EXPIRE);

   // Only the first entry that carries the id counts as a match.
   assign match = (ent_id == id_ff) && !found_ff;
   // An expiry drops the armed entry; a stop drops the matching one. Every
   // later entry then moves down one place as it is written back.
   assign skip  = (is_expire && (idx_ff[IDX_W-1:0] == armed_ff)) || (is_stop && match);
   assign take  = !best_valid_ff || alu_res.less;

   // Final step of an item: a start for a new id is appended if there is room.
   assign room         = (dst_ff < MAX_CNT);
   assign append       = is_start && !found_ff && room;
   assign fin_valid    = best_valid_ff || append;
   assign fin_best_t   = (append && take) ? tmo_ff : best_t_ff;
   assign fin_best_idx = (append && take) ? dst_ff[IDX_W-1:0] : best_idx_ff;

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in           = state_ff;
      mode_in            = mode_ff;
      id_in              = id_ff;
      tmo_in             = tmo_ff;
      rem_in             = rem_ff;
      count_in           = count_ff;
      armed_in           = armed_ff;
      amount_in          = amount_ff;
      idx_in             = idx_ff;
      dst_in             = dst_ff;
      found_in           = found_ff;
      best_valid_in      = best_valid_ff;
      best_t_in          = best_t_ff;
      best_idx_in        = best_idx_ff;
      fired_valid_in     = fired_valid_ff;
      fired_id_in        = fired_id_ff;
      out_valid_in       = out_valid_ff && !rsp_chan.ready;
      res_fired_valid_in = res_fired_valid_ff;
      res_fired_id_in    = res_fired_id_ff;
      res_prog_valid_in  = res_prog_valid_ff;
      res_prog_ms_in     = res_prog_ms_ff;
      res_full_in        = res_full_ff;
      ram_wr_en          = 1'b0;
      ram_wr_addr        = dst_ff[IDX_W-1:0];
      ram_wr_data        = {ent_id, alu_res.diff};
      ram_rd_en          = 1'b0;
      ram_rd_addr        = idx_ff[IDX_W-1:0];
      alu_req.a          = ent_t;
      alu_req.b          = '0;
      alu_req.cmp_val    = best_t_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               mode_in        = mode_type'(req_chan.mode);
               id_in          = req_id;
               tmo_in         = req_chan.timeout_ms;
               rem_in         = req_chan.remaining_ms;
               amount_in      = '0;
               idx_in         = '0;
               dst_in         = '0;
               found_in       = 1'b0;
               best_valid_in  = 1'b0;
               fired_valid_in = 1'b0;
               fired_id_in    = '0;
               if (count_ff == '0) begin
                  state_in = ST_FINISH;
               end else if ((mode_type'(req_chan.mode) == MODE_START) ||
                            (mode_type'(req_chan.mode) == MODE_EXPIRE)) begin
                  // Fetch the armed entry first: it sets the charge for the sweep.
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = armed_ff;
                  state_in    = ST_ARMED;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_ARMED: begin
            // A start charges the time the armed entry has run; an expiry
            // charges its whole timeout and reports it.
            alu_req.a = ent_t;
            alu_req.b = is_start ? rem_ff : '0;
            amount_in = alu_res.diff;
            if (is_expire) begin
               fired_valid_in = 1'b1;
               fired_id_in    = ent_id;
            end
            state_in = ST_READ;
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_PROC;
         end
         ST_PROC: begin
            if (is_start && match) begin
               alu_req.a = tmo_ff;
               alu_req.b = '0;
            end else if (is_start || is_expire) begin
               alu_req.b = amount_ff;
            end
            if ((is_start || is_stop) && match) begin
               found_in = 1'b1;
            end
            if (!skip) begin
               ram_wr_en = 1'b1;
               dst_in    = dst_ff + CNT_W'(1);
               if (take) begin
                  best_valid_in = 1'b1;
                  best_t_in     = alu_res.diff;
                  best_idx_in   = dst_ff[IDX_W-1:0];
               end
            end
            idx_in = idx_ff + CNT_W'(1);
            if ((idx_ff + CNT_W'(1)) == count_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_FINISH: begin
            alu_req.a       = tmo_ff;
            alu_req.b       = '0;
            alu_req.cmp_val = best_t_ff;
            if (!out_valid_ff || rsp_chan.ready) begin
               if (append) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {id_ff, tmo_ff};
               end
               count_in           = dst_ff + CNT_W'(append);
               armed_in           = fin_best_idx;
               out_valid_in       = 1'b1;
               res_fired_valid_in = fired_valid_ff;
               res_fired_id_in    = fired_id_ff;
               res_prog_valid_in  = fin_valid;
               res_prog_ms_in     = fin_valid ? fin_best_t : '0;
               res_full_in        = is_start && !found_ff && !room;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff            <= mode_in;
      id_ff              <= id_in;
      tmo_ff             <= tmo_in;
      rem_ff             <= rem_in;
      armed_ff           <= armed_in;
      amount_ff          <= amount_in;
      idx_ff             <= idx_in;
      dst_ff             <= dst_in;
      found_ff           <= found_in;
      best_valid_ff      <= best_valid_in;
      best_t_ff          <= best_t_in;
      best_idx_ff        <= best_idx_in;
      fired_valid_ff     <= fired_valid_in;
      fired_id_ff        <= fired_id_in;
      res_fired_valid_ff <= res_fired_valid_in;
      res_fired_id_ff    <= res_fired_id_in;
      res_prog_valid_ff  <= res_prog_valid_in;
      res_prog_ms_ff     <= res_prog_ms_in;
      res_full_ff        <= res_full_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.fired_valid   = res_fired_valid_ff;
   assign rsp_chan.fired_id      = fired_id_port;
   assign rsp_chan.program_valid = res_prog_valid_ff;
   assign rsp_chan.program_ms    = res_prog_ms_ff;
   assign rsp_chan.table_full    = res_full_ff;

endmodule

`default_nettype wire

[rtl/mts_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing but its parameters.
`default_nettype none

module mts_ram #(
   parameter  int WIDTH = 24,
   parameter  int DEPTH = 8,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire                clock,
   input  wire                wr_en,
   input  wire [AW-1:0]       wr_addr,
   input  wire [WIDTH-1:0]    wr_data,
   input  wire                rd_en,
   input  wire [AW-1:0]       rd_addr,
   output logic [WIDTH-1:0]   rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/mts_alu.sv]
// Shared arithmetic unit: saturating subtract followed by a less-than compare.
// Depends on mts_pkg for the request and result structs.
`default_nettype none

module mts_alu import mts_pkg::*; (
   input  alu_req_type alu_req,
   output alu_res_type alu_res
);

   logic [MS_W-1:0] diff;

   // The difference is clamped at zero, then compared with the running best.
   assign diff         = (alu_req.a > alu_req.b) ? (alu_req.a - alu_req.b) : '0;
   assign alu_res.diff = diff;
   assign alu_res.less = (diff < alu_req.cmp_val);

endmodule

`default_nettype wire

[rtl/mts_checker.sv]
// Port-level checker of the timeout scheduler and its bind to the top level.
// Depends on mts_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mts_checker import mts_pkg::*; (
   input wire                 clock,
   input wire                 reset,
   input wire                 req_valid,
   input wire                 req_ready,
   input wire                 rsp_valid,
   input wire                 rsp_ready,
   input wire                 fired_valid,
   input wire [ID_PORT_W-1:0] fired_id,
   input wire                 program_valid,
   input wire [MS_W-1:0]      program_ms,
   input wire                 table_full
);

   // A stalled response keeps its payload.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(fired_valid) && $stable(fired_id) && $stable(program_valid) && $stable(program_ms) && $stable(table_full))

   // The block is busy in the cycle after it takes a request.
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // Fields without their valid flag read as zero.
   `ASSERT_SAME(a_zero_fields, clock, reset, rsp_valid, (program_valid || (program_ms == '0)) && (fired_valid || (fired_id == '0)))

   // A refused start never reports an expiry.
   `ASSERT_SAME(a_full_not_fired, clock, reset, rsp_valid && table_full, !fired_valid)

   // Reset leaves the block idle with no response pending.
   `ASSERT_NEXT_ANY(a_reset_idle, clock, reset, !rsp_valid && req_ready)

endmodule

bind multiplexed_timeout_scheduler mts_checker u_mts_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .fired_valid   (rsp_chan.fired_valid),
   .fired_id      (rsp_chan.fired_id),
   .program_valid (rsp_chan.program_valid),
   .program_ms    (rsp_chan.program_ms),
   .table_full    (rsp_chan.table_full)
);

`default_nettype wire
